@@ rtl/bcs_pkg.sv @@
// shared constants, codes, transaction types and the reset curve for the curve scanner
`default_nettype none

package bcs_pkg;

  // sizing of the core
  localparam int CURVE_POINTS    = 32;
  localparam int PHASE_FRAC_BITS = 24;
  localparam int VALUE_BITS      = 16;

  // fixed port field widths
  localparam int STEP_W     = 24;
  localparam int MODE_W     = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int REQ_W      = 2;
  localparam int MOD_W      = 16;
  localparam int PIDX_W     = 5;
  localparam int PVAL_W     = 16;
  localparam int POS_W      = 16;
  localparam int PLAYHEAD_W = 25;

  // derived widths
  localparam int IDX_W    = $clog2(CURVE_POINTS);
  localparam int PHASE_W  = PHASE_FRAC_BITS + 1;
  localparam int WORK_W   = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;
  localparam int SCALED_W = PHASE_W + IDX_W;
  localparam int DIFF_W   = VALUE_BITS + 1;
  localparam int PROD_W   = DIFF_W + PHASE_FRAC_BITS + 1;
  localparam int SUM_W    = ((VALUE_BITS > MOD_W) ? VALUE_BITS : MOD_W) + 2;

  // queue sizing, depths are powers of two
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH  = 8;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  localparam logic [PHASE_W-1:0]    PH_ONE     = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
  localparam logic [VALUE_BITS-1:0] VMAX       = '1;
  localparam logic [IDX_W-1:0]      CURVE_LAST = IDX_W'(CURVE_POINTS - 1);
  localparam logic [STEP_W-1:0]     STEP_RESET = STEP_W'(70);

  localparam longint VMAX_INT  = (longint'(1) << VALUE_BITS) - 1;
  localparam longint RAMP_DEN  = longint'(2 * (CURVE_POINTS - 1));

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_RESTART = 2'd2
  } req_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_SCAN_MODE  = 2'd1,
    CFG_STEPPED    = 2'd2
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    SCAN_FWD_WRAP = 3'd0,
    SCAN_FWD_STOP = 3'd1,
    SCAN_BOUNCE   = 3'd2,
    SCAN_BWD_STOP = 3'd3,
    SCAN_BWD_WRAP = 3'd4
  } scan_mode_t;

  typedef struct packed {
    req_t                    kind;
    logic signed [MOD_W-1:0] mod;
    logic [IDX_W-1:0]        idx;
    logic [VALUE_BITS-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]      position;
    logic [PLAYHEAD_W-1:0] playhead;
    logic                  finished;
  } result_t;

  typedef logic [VALUE_BITS-1:0] curve_arr_t [CURVE_POINTS];

  // linear ramp, entry i is i/(points-1) of full scale, rounded
  function automatic curve_arr_t ramp_init();
    curve_arr_t r;
    longint     num;
    for (int i = 0; i < CURVE_POINTS; i++) begin
      num  = longint'(i) * VMAX_INT * 2 + longint'(CURVE_POINTS - 1);
      r[i] = VALUE_BITS'(num / RAMP_DEN);
    end
    return r;
  endfunction

  localparam curve_arr_t CURVE_RESET = ramp_init();

endpackage

`default_nettype wire

@@ rtl/bcs_front.sv @@
// front end: accepts requests, sorts out unused codes, clamps write fields, command queue
`default_nettype none

module bcs_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [bcs_pkg::REQ_W-1:0]      req_type,
  input  wire logic signed [bcs_pkg::MOD_W-1:0] mod_offset,
  input  wire logic [bcs_pkg::PIDX_W-1:0]     point_index,
  input  wire logic [bcs_pkg::PVAL_W-1:0]     point_value,
  output logic                                cmd_valid,
  output bcs_pkg::cmd_t                       cmd,
  input  wire logic                           cmd_take
);

  bcs_pkg::cmd_t                    q [bcs_pkg::CMD_DEPTH];
  logic [bcs_pkg::CMD_PTR_W-1:0]    wr_ptr;
  logic [bcs_pkg::CMD_PTR_W-1:0]    rd_ptr;
  logic [bcs_pkg::CMD_CNT_W-1:0]    count;

  bcs_pkg::cmd_t cmd_in;
  logic          keep;
  logic          store;
  logic          take;

  always_comb begin
    keep = 1'b0;
    case (req_type)
      bcs_pkg::REQ_TICK, bcs_pkg::REQ_WRITE, bcs_pkg::REQ_RESTART: keep = 1'b1;
      default: keep = 1'b0;
    endcase

    cmd_in.kind = bcs_pkg::req_t'(req_type);
    cmd_in.mod  = mod_offset;
    if (32'(point_index) > 32'(bcs_pkg::CURVE_POINTS - 1)) begin
      cmd_in.idx = bcs_pkg::CURVE_LAST;
    end else begin
      cmd_in.idx = bcs_pkg::IDX_W'(point_index);
    end
    if (32'(point_value) > 32'(bcs_pkg::VMAX)) begin
      cmd_in.value = bcs_pkg::VMAX;
    end else begin
      cmd_in.value = bcs_pkg::VALUE_BITS'(point_value);
    end
  end

  assign full      = (count == bcs_pkg::CMD_CNT_W'(bcs_pkg::CMD_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  // an unused request code is taken but never queued
  assign store = push && !full && keep;
  assign take  = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (store) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (store) begin
        wr_ptr <= wr_ptr + bcs_pkg::CMD_PTR_W'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + bcs_pkg::CMD_PTR_W'(1);
      end
      case ({store, take})
        2'b10:   count <= count + bcs_pkg::CMD_CNT_W'(1);
        2'b01:   count <= count - bcs_pkg::CMD_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/bcs_engine.sv @@
// back end: config registers, playhead advance, curve table and interpolation pipeline
`default_nettype none

module bcs_engine (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [bcs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [bcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              cmd_valid,
  input  wire bcs_pkg::cmd_t                     cmd,
  output logic                                   cmd_take,
  input  wire logic [bcs_pkg::OUT_CNT_W-1:0]     out_level,
  output logic                                   res_push,
  output bcs_pkg::result_t                       res
);

  localparam int OCC_W = bcs_pkg::OUT_CNT_W + 1;

  // configuration
  logic [bcs_pkg::STEP_W-1:0] phase_step;
  logic [bcs_pkg::MODE_W-1:0] scan_mode;
  logic                       stepped;

  // playhead state
  logic [bcs_pkg::PHASE_W-1:0] phase;
  logic                        going_down;
  logic                        halted;

  // curve store, unwritten points read as the ramp
  logic [bcs_pkg::VALUE_BITS-1:0]   curve_mem [bcs_pkg::CURVE_POINTS];
  logic [bcs_pkg::CURVE_POINTS-1:0] pt_valid;

  // issue
  logic [OCC_W-1:0] occ;
  logic             credit_ok;
  logic             is_tick;
  logic             is_write;
  logic             is_restart;

  // advance
  logic signed [bcs_pkg::WORK_W-1:0] ps;
  logic signed [bcs_pkg::WORK_W-1:0] st;
  logic signed [bcs_pkg::WORK_W-1:0] one_s;
  logic signed [bcs_pkg::WORK_W-1:0] up;
  logic signed [bcs_pkg::WORK_W-1:0] dn;
  logic signed [bcs_pkg::WORK_W-1:0] mv;
  logic [bcs_pkg::PHASE_W-1:0]       phase_adv;
  logic                              down_adv;
  logic                              halt_adv;

  // stage 1: address generation
  logic                              s1_valid;
  logic [bcs_pkg::PHASE_W-1:0]       s1_phase;
  logic                              s1_halted;
  logic signed [bcs_pkg::MOD_W-1:0]  s1_mod;
  logic [bcs_pkg::PHASE_W-1:0]       t;
  logic [bcs_pkg::SCALED_W-1:0]      scaled;
  logic [bcs_pkg::IDX_W:0]           i0_full;
  logic [bcs_pkg::IDX_W-1:0]         i0;
  logic [bcs_pkg::IDX_W-1:0]         i1;

  // stage 2: table data
  logic                              s2_valid;
  logic [bcs_pkg::PHASE_W-1:0]       s2_phase;
  logic                              s2_halted;
  logic signed [bcs_pkg::MOD_W-1:0]  s2_mod;
  logic [bcs_pkg::PHASE_FRAC_BITS-1:0] s2_frac;
  logic [bcs_pkg::VALUE_BITS-1:0]    rd0;
  logic [bcs_pkg::VALUE_BITS-1:0]    rd1;
  logic                              vld0;
  logic                              vld1;
  logic [bcs_pkg::VALUE_BITS-1:0]    ramp0;
  logic [bcs_pkg::VALUE_BITS-1:0]    ramp1;
  logic [bcs_pkg::VALUE_BITS-1:0]    v0;
  logic [bcs_pkg::VALUE_BITS-1:0]    v1;
  logic signed [bcs_pkg::DIFF_W-1:0] diff;

  // stage 3: product and output shaping
  logic                              s3_valid;
  logic [bcs_pkg::PHASE_W-1:0]       s3_phase;
  logic                              s3_halted;
  logic signed [bcs_pkg::MOD_W-1:0]  s3_mod;
  logic [bcs_pkg::VALUE_BITS-1:0]    s3_v0;
  logic signed [bcs_pkg::PROD_W-1:0] s3_prod;
  logic signed [bcs_pkg::PROD_W-1:0] rnd;
  logic signed [bcs_pkg::PROD_W-1:0] rnd_sh;
  logic signed [bcs_pkg::SUM_W-1:0]  v0_s;
  logic signed [bcs_pkg::SUM_W-1:0]  adj_s;
  logic signed [bcs_pkg::SUM_W-1:0]  base_s;
  logic signed [bcs_pkg::SUM_W-1:0]  pos_s;
  logic [bcs_pkg::VALUE_BITS-1:0]    pos_val;

  localparam logic signed [bcs_pkg::PROD_W-1:0] HALF =
    bcs_pkg::PROD_W'(1) << (bcs_pkg::PHASE_FRAC_BITS - 1);
  localparam logic signed [bcs_pkg::SUM_W-1:0] VMAX_S = bcs_pkg::SUM_W'(bcs_pkg::VMAX);

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= bcs_pkg::STEP_RESET;
      scan_mode  <= bcs_pkg::SCAN_FWD_WRAP;
      stepped    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        bcs_pkg::CFG_PHASE_STEP: phase_step <= cfg_wdata[bcs_pkg::STEP_W-1:0];
        bcs_pkg::CFG_SCAN_MODE:  scan_mode  <= cfg_wdata[bcs_pkg::MODE_W-1:0];
        bcs_pkg::CFG_STEPPED:    stepped    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- issue ----------------
  // ticks only go when a result slot is certain to be free
  assign occ = OCC_W'(out_level) + OCC_W'(s1_valid) + OCC_W'(s2_valid) + OCC_W'(s3_valid);
  assign credit_ok = (occ < OCC_W'(bcs_pkg::OUT_DEPTH));
  assign cmd_take  = cmd_valid && ((cmd.kind != bcs_pkg::REQ_TICK) || credit_ok);
  assign is_tick    = cmd_take && (cmd.kind == bcs_pkg::REQ_TICK);
  assign is_write   = cmd_take && (cmd.kind == bcs_pkg::REQ_WRITE);
  assign is_restart = cmd_take && (cmd.kind == bcs_pkg::REQ_RESTART);

  // ---------------- playhead advance ----------------
  assign ps    = bcs_pkg::WORK_W'(phase);
  assign st    = bcs_pkg::WORK_W'(phase_step);
  assign one_s = bcs_pkg::WORK_W'(bcs_pkg::PH_ONE);
  assign up    = ps + st;
  assign dn    = ps - st;

  always_comb begin
    phase_adv = phase;
    down_adv  = going_down;
    halt_adv  = halted;
    mv        = going_down ? dn : up;
    if (!halted) begin
      case (scan_mode)
        bcs_pkg::SCAN_FWD_WRAP: begin
          phase_adv = (up >= one_s) ? bcs_pkg::PHASE_W'(up - one_s) : bcs_pkg::PHASE_W'(up);
        end
        bcs_pkg::SCAN_FWD_STOP: begin
          if (up >= one_s) begin
            phase_adv = bcs_pkg::PH_ONE;
            halt_adv  = 1'b1;
          end else begin
            phase_adv = bcs_pkg::PHASE_W'(up);
          end
        end
        bcs_pkg::SCAN_BOUNCE: begin
          if (mv >= one_s) begin
            phase_adv = bcs_pkg::PH_ONE;
            down_adv  = 1'b1;
          end else if (mv[bcs_pkg::WORK_W-1] || (mv == '0)) begin
            phase_adv = '0;
            down_adv  = 1'b0;
          end else begin
            phase_adv = bcs_pkg::PHASE_W'(mv);
          end
        end
        bcs_pkg::SCAN_BWD_STOP: begin
          if (dn[bcs_pkg::WORK_W-1] || (dn == '0)) begin
            phase_adv = '0;
            halt_adv  = 1'b1;
          end else begin
            phase_adv = bcs_pkg::PHASE_W'(dn);
          end
        end
        default: begin
          // backward wrap, unused codes behave the same; exact zero lands on 1.0
          if (dn[bcs_pkg::WORK_W-1] || (dn == '0)) begin
            phase_adv = bcs_pkg::PHASE_W'(dn + one_s);
          end else begin
            phase_adv = bcs_pkg::PHASE_W'(dn);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      going_down <= 1'b0;
      halted     <= 1'b0;
    end else if (is_tick) begin
      phase      <= phase_adv;
      going_down <= down_adv;
      halted     <= halt_adv;
    end else if (is_restart) begin
      phase      <= '0;
      going_down <= 1'b0;
      halted     <= 1'b0;
    end
  end

  // ---------------- curve store ----------------
  always_ff @(posedge clk) begin
    if (is_write) begin
      curve_mem[cmd.idx] <= cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= '0;
    end else if (is_write) begin
      pt_valid[cmd.idx] <= 1'b1;
    end
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= is_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) begin
      s1_phase  <= phase_adv;
      s1_halted <= halt_adv;
      s1_mod    <= cmd.mod;
    end
  end

  assign t       = (s1_phase > bcs_pkg::PH_ONE) ? bcs_pkg::PH_ONE : s1_phase;
  assign scaled  = bcs_pkg::SCALED_W'(t) * bcs_pkg::SCALED_W'(bcs_pkg::CURVE_POINTS - 1);
  assign i0_full = scaled[bcs_pkg::SCALED_W-1:bcs_pkg::PHASE_FRAC_BITS];
  assign i0      = (i0_full > {1'b0, bcs_pkg::CURVE_LAST}) ? bcs_pkg::CURVE_LAST
                                                           : i0_full[bcs_pkg::IDX_W-1:0];
  assign i1      = (i0 == bcs_pkg::CURVE_LAST) ? bcs_pkg::CURVE_LAST
                                               : i0 + bcs_pkg::IDX_W'(1);

  // ---------------- stage 2 ----------------
  // reads see writes issued on earlier cycles only, which keeps request order
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    rd0       <= curve_mem[i0];
    rd1       <= curve_mem[i1];
    vld0      <= pt_valid[i0];
    vld1      <= pt_valid[i1];
    ramp0     <= bcs_pkg::CURVE_RESET[i0];
    ramp1     <= bcs_pkg::CURVE_RESET[i1];
    s2_frac   <= scaled[bcs_pkg::PHASE_FRAC_BITS-1:0];
    s2_phase  <= s1_phase;
    s2_halted <= s1_halted;
    s2_mod    <= s1_mod;
  end

  assign v0   = vld0 ? rd0 : ramp0;
  assign v1   = vld1 ? rd1 : ramp1;
  assign diff = $signed({1'b0, v1}) - $signed({1'b0, v0});

  // ---------------- stage 3 ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_v0     <= v0;
    s3_prod   <= diff * $signed({1'b0, s2_frac});
    s3_phase  <= s2_phase;
    s3_halted <= s2_halted;
    s3_mod    <= s2_mod;
  end

  // v0 + (v1 - v0) * frac, rounded half up, or v0 alone when stepped
  assign rnd    = s3_prod + HALF;
  assign rnd_sh = rnd >>> bcs_pkg::PHASE_FRAC_BITS;
  assign adj_s  = $signed(rnd_sh[bcs_pkg::SUM_W-1:0]);
  assign v0_s   = $signed(bcs_pkg::SUM_W'(s3_v0));
  assign base_s = stepped ? v0_s : (v0_s + adj_s);
  assign pos_s  = base_s + bcs_pkg::SUM_W'(s3_mod);

  always_comb begin
    if (pos_s[bcs_pkg::SUM_W-1]) begin
      pos_val = '0;
    end else if (pos_s > VMAX_S) begin
      pos_val = bcs_pkg::VMAX;
    end else begin
      pos_val = pos_s[bcs_pkg::VALUE_BITS-1:0];
    end
  end

  assign res_push     = s3_valid;
  assign res.position = bcs_pkg::POS_W'(pos_val);
  assign res.playhead = bcs_pkg::PLAYHEAD_W'(s3_phase);
  assign res.finished = s3_halted;

  // ---------------- checks ----------------
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= bcs_pkg::PH_ONE)
    else $error("playhead phase above 1.0");

  a_halt_stop_mode: assert property (@(posedge clk) disable iff (rst)
    $rose(halted) |-> ($past(scan_mode) == bcs_pkg::SCAN_FWD_STOP ||
                       $past(scan_mode) == bcs_pkg::SCAN_BWD_STOP))
    else $error("finished flag set outside a stop mode");

  a_credit: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(bcs_pkg::OUT_DEPTH))
    else $error("ticks in flight exceed result queue space");

endmodule

`default_nettype wire

@@ rtl/bcs_result_queue.sv @@
// result queue: holds finished tick results until the consumer pops them
`default_nettype none

module bcs_result_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          res_push,
  input  wire bcs_pkg::result_t              res,
  output logic [bcs_pkg::OUT_CNT_W-1:0]      level,
  output logic                               empty,
  input  wire logic                          pop,
  output bcs_pkg::result_t                   head
);

  bcs_pkg::result_t              q [bcs_pkg::OUT_DEPTH];
  logic [bcs_pkg::OUT_PTR_W-1:0] wr_ptr;
  logic [bcs_pkg::OUT_PTR_W-1:0] rd_ptr;
  logic                          take;

  assign empty = (level == '0);
  assign head  = q[rd_ptr];
  assign take  = pop && !empty;

  always_ff @(posedge clk) begin
    if (res_push) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + bcs_pkg::OUT_PTR_W'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + bcs_pkg::OUT_PTR_W'(1);
      end
      case ({res_push, take})
        2'b10:   level <= level + bcs_pkg::OUT_CNT_W'(1);
        2'b01:   level <= level - bcs_pkg::OUT_CNT_W'(1);
        default: level <= level;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (level != bcs_pkg::OUT_CNT_W'(bcs_pkg::OUT_DEPTH)))
    else $error("result pushed into a full queue");

endmodule

`default_nettype wire

@@ rtl/breakpoint_curve_scanner.sv @@
// top level of the breakpoint curve scanner: front end, engine and result queue
//
//   channel   handshake                 payload
//   input     push / full               req_type, mod_offset, point_index, point_value
//   result    empty / pop               position, playhead, finished
//   config    cfg_we                    cfg_addr, cfg_wdata
//
// one transaction per cycle sustained while result space lasts; a taken tick passes the
// address, table read and multiply stages and is then written into the result queue.
// writes and restarts take one engine slot and give no result; req_type 3 is dropped.
// rst is synchronous; curve points read as the ramp until written, so no clearing pass.
// with pop low, up to eight results wait, then ticks hold in the four-entry command
// queue and full rises.
`default_nettype none

module breakpoint_curve_scanner (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [bcs_pkg::REQ_W-1:0]         req_type,
  input  wire logic signed [bcs_pkg::MOD_W-1:0]  mod_offset,
  input  wire logic [bcs_pkg::PIDX_W-1:0]        point_index,
  input  wire logic [bcs_pkg::PVAL_W-1:0]        point_value,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [bcs_pkg::POS_W-1:0]              position,
  output logic [bcs_pkg::PLAYHEAD_W-1:0]         playhead,
  output logic                                   finished,
  input  wire logic                              cfg_we,
  input  wire logic [bcs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [bcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic                              cmd_valid;
  logic                              cmd_take;
  bcs_pkg::cmd_t                     cmd;
  logic                              res_push;
  bcs_pkg::result_t                  res;
  bcs_pkg::result_t                  head;
  logic [bcs_pkg::OUT_CNT_W-1:0]     out_level;

  bcs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .mod_offset  (mod_offset),
    .point_index (point_index),
    .point_value (point_value),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  bcs_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_level (out_level),
    .res_push  (res_push),
    .res       (res)
  );

  bcs_result_queue u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .level    (out_level),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign position = head.position;
  assign playhead = head.playhead;
  assign finished = head.finished;

endmodule

`default_nettype wire
